// ----- rtl/core/rip_pkg.sv -----
// Shared types and constants for the radix integer parser core.
// Depends on nothing; imported by every module of the core.
package rip_pkg;

  // Longest string length tracked by the consumed counter (it saturates here)
  localparam int MAX_LEN = 4096;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);

  // Front-to-back queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int VALUE_W   = 64;
  localparam int CONS_W    = 13;
  localparam int STATUS_W  = 2;
  localparam int BASE_W    = 6;
  localparam int MODE_W    = 2;
  localparam int OUT_TDATA_W = 80;

  // Register indexes on the config port
  localparam logic REG_BASE_SELECT = 1'b0;
  localparam logic REG_RESULT_MODE = 1'b1;

  // Result modes
  localparam logic [MODE_W-1:0] MODE_S64 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_U64 = 2'd1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVF      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_BASE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_MINUS    = 2'd3;

  localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

  typedef enum logic [2:0] {
    PH_START,
    PH_WS,
    PH_PREFIX,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // One classified string byte
  typedef struct packed {
    logic              is_nul;
    logic              is_ws;
    logic              is_plus;
    logic              is_minus;
    logic              is_zero;   // the character '0'
    logic              is_x;      // 'x' or 'X'
    logic              is_digit;  // 0-9, a-z, A-Z
    logic [BASE_W-1:0] dval;      // digit value 0..35
    logic              last;
  } cls_t;

endpackage

// ----- rtl/core/rip_front.sv -----
// Front end: takes string bytes off the input stream and classifies them.
// Depends on rip_pkg; feeds rip_queue.
module rip_front (
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  input  logic          q_ready,
  output logic          q_push,
  output rip_pkg::cls_t q_entry
);
  import rip_pkg::*;

  logic [7:0] ch;

  assign ch        = in_tdata;
  assign in_tready = q_ready;
  assign q_push    = in_tvalid && q_ready;

  always_comb begin
    q_entry          = '0;
    q_entry.last     = in_tlast;
    q_entry.is_nul   = (ch == 8'h00);
    q_entry.is_ws    = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));
    q_entry.is_plus  = (ch == 8'h2B);
    q_entry.is_minus = (ch == 8'h2D);
    q_entry.is_zero  = (ch == 8'h30);
    q_entry.is_x     = (ch == 8'h78) || (ch == 8'h58);
    if ((ch >= 8'h30) && (ch <= 8'h39)) begin
      q_entry.is_digit = 1'b1;
      q_entry.dval     = BASE_W'(ch - 8'h30);
    end else if ((ch >= 8'h61) && (ch <= 8'h7A)) begin
      q_entry.is_digit = 1'b1;
      q_entry.dval     = BASE_W'(ch - 8'h61) + 6'd10;
    end else if ((ch >= 8'h41) && (ch <= 8'h5A)) begin
      q_entry.is_digit = 1'b1;
      q_entry.dval     = BASE_W'(ch - 8'h41) + 6'd10;
    end
  end

endmodule

// ----- rtl/core/rip_queue.sv -----
// Short FIFO of classified bytes between the front end and the parse engine.
// Depends on rip_pkg.
module rip_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rip_pkg::cls_t push_data,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output rip_pkg::cls_t head
);
  import rip_pkg::*;

  cls_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_pop;

  assign ready  = (count_r != (QPTR_W+1)'(QDEPTH));
  assign valid  = (count_r != '0);
  assign head   = mem_r[rd_ptr_r];
  assign do_pop = pop && valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/core/rip_back.sv -----
// Parse engine: whitespace/sign/prefix state machine, digit accumulate with
// overflow check, and the registered result slot. Depends on rip_pkg.
module rip_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  input  rip_pkg::cls_t                  q_head,
  output logic                           q_pop,
  input  logic [rip_pkg::BASE_W-1:0]     cfg_base,
  input  logic [rip_pkg::MODE_W-1:0]     cfg_mode,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rip_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rip_pkg::*;

  function automatic logic [CNT_W-1:0] cnt_add(input logic [CNT_W-1:0] cnt,
                                               input logic [1:0] n);
    logic [CNT_W:0] s;
    s = {1'b0, cnt} + (CNT_W+1)'(n);
    return (s > (CNT_W+1)'(MAX_LEN)) ? CNT_W'(MAX_LEN) : s[CNT_W-1:0];
  endfunction

  phase_t              ph_r, ph_nxt;
  logic [VALUE_W-1:0]  acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic [BASE_W-1:0]   ab_r, ab_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic [BASE_W-1:0]   base_latch_r, base_l;
  logic [MODE_W-1:0]   mode_latch_r, mode_l;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  cls_t                c;
  logic                bad_base, pfx, do_take, fail, fin, out_free;
  logic [STATUS_W-1:0] fail_code;
  logic [VALUE_W-1:0]  lim, value;
  logic [VALUE_W+BASE_W-1:0] prod, sum;

  assign c          = q_head;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    base_l   = (ph_r == PH_START) ? cfg_base : base_latch_r;
    mode_l   = (ph_r == PH_START) ? cfg_mode : mode_latch_r;
    bad_base = (base_l == 6'd1) || (base_l > BASE_MAX);
    if (mode_l == MODE_S64)      lim = {1'b0, {(VALUE_W-1){1'b1}}};
    else if (mode_l == MODE_U64) lim = '1;
    else                         lim = {32'd0, 32'hFFFF_FFFF};

    ph_nxt    = (ph_r == PH_START) ? PH_WS : ph_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    ab_nxt    = ab_r;
    cnt_nxt   = cnt_r;
    st_nxt    = st_r;
    pfx       = 1'b0;
    do_take   = 1'b0;
    fail      = 1'b0;
    fail_code = ST_OK;

    case (ph_r)
      PH_START, PH_WS: begin
        if (c.is_ws) begin
          cnt_nxt = cnt_add(cnt_r, 2'd1);
        end else if (c.is_plus) begin
          cnt_nxt = cnt_add(cnt_r, 2'd1);
          ph_nxt  = PH_PREFIX;
        end else if (c.is_minus) begin
          if (mode_l != MODE_S64) begin
            fail      = 1'b1;
            fail_code = ST_MINUS;
          end else begin
            neg_nxt = 1'b1;
            cnt_nxt = cnt_add(cnt_r, 2'd1);
            ph_nxt  = PH_PREFIX;
          end
        end else begin
          pfx = 1'b1;
        end
      end
      PH_PREFIX: pfx = 1'b1;
      PH_ZERO: begin
        ph_nxt = PH_DIGITS;
        if (c.is_x) begin
          cnt_nxt = cnt_add(cnt_r, 2'd2);
          ab_nxt  = 6'd16;
        end else begin
          cnt_nxt = cnt_add(cnt_r, 2'd1);
          ab_nxt  = (base_l == 6'd0) ? 6'd8 : 6'd16;
          do_take = 1'b1;
        end
      end
      PH_DIGITS: do_take = 1'b1;
      default: ;
    endcase

    // radix prefix position
    if (pfx) begin
      if (bad_base) begin
        fail      = 1'b1;
        fail_code = ST_BAD_BASE;
      end else if (((base_l == 6'd0) || (base_l == 6'd16)) && c.is_zero) begin
        ph_nxt = PH_ZERO;
      end else begin
        ab_nxt  = (base_l == 6'd0) ? 6'd10 : base_l;
        ph_nxt  = PH_DIGITS;
        do_take = 1'b1;
      end
    end

    // digit: acc*base + d must stay within the mode limit
    prod = {{BASE_W{1'b0}}, acc_r} * {{VALUE_W{1'b0}}, ab_nxt};
    sum  = prod + {{VALUE_W{1'b0}}, c.dval};
    if (do_take) begin
      if (!c.is_digit || (ab_nxt < 6'd2) || (c.dval >= ab_nxt)) begin
        ph_nxt = PH_DONE;
      end else if (sum > {{BASE_W{1'b0}}, lim}) begin
        st_nxt = ST_OVF;
        ph_nxt = PH_DONE;
      end else begin
        acc_nxt = sum[VALUE_W-1:0];
        cnt_nxt = cnt_add(cnt_nxt, 2'd1);
      end
    end

    if (fail) begin
      st_nxt  = fail_code;
      cnt_nxt = '0;
      acc_nxt = '0;
      neg_nxt = 1'b0;
      ph_nxt  = PH_DONE;
    end

    // tlast on a non-NUL byte: behave as if a NUL followed it
    if (!c.is_nul && c.last) begin
      case (ph_nxt)
        PH_WS, PH_PREFIX: begin
          if (bad_base) begin
            st_nxt  = ST_BAD_BASE;
            cnt_nxt = '0;
            acc_nxt = '0;
            neg_nxt = 1'b0;
            ph_nxt  = PH_DONE;
          end
        end
        PH_ZERO: cnt_nxt = cnt_add(cnt_nxt, 2'd1);
        default: ;
      endcase
    end

    if (st_nxt == ST_OVF) begin
      if (mode_l == MODE_S64) value = neg_nxt ? {1'b1, {(VALUE_W-1){1'b0}}} : lim;
      else                    value = lim;
    end else begin
      value = neg_nxt ? (VALUE_W'(0) - acc_nxt) : acc_nxt;
    end
    out_data_nxt = {1'b0, st_nxt, CONS_W'(cnt_nxt), value};

    fin      = c.is_nul || c.last;
    out_free = !out_valid_r || out_tready;
    q_pop    = q_valid && (!fin || out_free);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r         <= PH_START;
      acc_r        <= '0;
      neg_r        <= 1'b0;
      ab_r         <= '0;
      cnt_r        <= '0;
      st_r         <= ST_OK;
      base_latch_r <= '0;
      mode_latch_r <= '0;
    end else if (q_pop) begin
      if (fin) begin
        ph_r         <= PH_START;
        acc_r        <= '0;
        neg_r        <= 1'b0;
        ab_r         <= '0;
        cnt_r        <= '0;
        st_r         <= ST_OK;
        base_latch_r <= '0;
        mode_latch_r <= '0;
      end else begin
        ph_r         <= ph_nxt;
        acc_r        <= acc_nxt;
        neg_r        <= neg_nxt;
        ab_r         <= ab_nxt;
        cnt_r        <= cnt_nxt;
        st_r         <= st_nxt;
        base_latch_r <= base_l;
        mode_latch_r <= mode_l;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && fin) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && fin) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- rtl/core/radix_integer_parser_core.sv -----
// Path: a string byte is written into the queue and parsed when the back end pops it;
//   the result of the byte that ends the string is registered onto out_tvalid.
// Throughput: one byte per cycle unless a string-ending byte waits for the result
//   slot; the digit step (64x6 multiply, add, limit compare) is combinational in the back end.
// Reset (rst_n low, synchronous): queue empty, parser at string start,
//   no result pending, base_select = 10, result_mode = 0.
module radix_integer_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_addr,     // register index
  input  logic [5:0]  cfg_wdata,
  // string bytes in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] ch
  input  logic        in_tlast,     // last byte of the string
  // parse results out
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata     // [63:0] value, [76:64] consumed, [78:77] status
);
  import rip_pkg::*;

  logic [BASE_W-1:0] base_select_r;
  logic [MODE_W-1:0] result_mode_r;

  logic q_ready, q_push, q_valid, q_pop;
  cls_t q_entry, q_head;

  // Config registers; the back end samples them on the first byte of a string
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_select_r <= 6'd10;
      result_mode_r <= MODE_S64;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BASE_SELECT: base_select_r <= cfg_wdata;
        REG_RESULT_MODE: result_mode_r <= cfg_wdata[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Front end: classify each request's byte and push it into the queue
  rip_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  // Decouples input acceptance from result backpressure
  rip_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .ready     (q_ready),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // Back end: parse state machine plus the result register. It keeps
  // consuming mid-string bytes while a result waits; only a string-ending
  // byte waits for the result slot.
  rip_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .cfg_base   (base_select_r),
    .cfg_mode   (result_mode_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Failed parses report a zero value and zero consumed count
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tdata[78:77] == ST_BAD_BASE) || (out_tdata[78:77] == ST_MINUS))
    |-> (out_tdata[76:0] == 77'd0))
    else $error("failed parse with nonzero value or count");

  // Consumed count never passes the saturation point
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[76:64] <= 13'(MAX_LEN)))
    else $error("consumed count above saturation");

  // Overflow with the top bit set saturates to the most negative value (signed) or to all ones (unsigned)
  a_ovf_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[78:77] == ST_OVF) && out_tdata[63]
    |-> (out_tdata[62:0] == 63'd0) || (out_tdata[62:0] == {63{1'b1}}))
    else $error("bad overflow saturation value");

  // No result is left pending across reset
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule
